[rtl/tbt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tbt_pkg: shared constants, types and functions of the touch baseline tracker
// Register map, field widths, reset values and the shift-based IIR step used
// for both the filtered value and the baseline.
// ----------------------------------------------------------------------------
package tbt_pkg;

    // channel and field widths
    localparam int CHANNELS  = 2;
    localparam int CH_W      = 1;
    localparam int LEVEL_W   = 16;
    localparam int SHIFT_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // calibration sizing
    localparam int CALIB_SAMPLES = 32;
    localparam int COUNT_W       = $clog2(CALIB_SAMPLES + 1);
    localparam int SUM_W         = LEVEL_W + $clog2(CALIB_SAMPLES + 1);

    // width of the IIR accumulator: level shifted by the largest shift, plus carry
    localparam int ACC_W = LEVEL_W + (1 << SHIFT_W);

    // register reset values
    localparam logic [LEVEL_W-1:0] TOUCH_DELTA_RST    = LEVEL_W'(25);
    localparam logic [SHIFT_W-1:0] FILTER_SHIFT_RST   = SHIFT_W'(2);
    localparam logic [SHIFT_W-1:0] BASELINE_SHIFT_RST = SHIFT_W'(4);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOUCH_DELTA    = 2'd0,
        REG_FILTER_SHIFT   = 2'd1,
        REG_BASELINE_SHIFT = 2'd2
    } t_cfg_reg;

    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [SUM_W-1:0]   t_sum;
    typedef logic [COUNT_W-1:0] t_count;

    // one IIR step: (old*(2^sh-1) + incoming) >> sh, done with shifts and adds
    function automatic t_level iir_step(input t_level old, input t_level incoming,
                                        input logic [SHIFT_W-1:0] sh);
        logic [ACC_W-1:0] old_x;
        logic [ACC_W-1:0] acc;
        old_x = ACC_W'(old);
        acc   = (old_x << sh) - old_x + ACC_W'(incoming);
        return LEVEL_W'(acc >> sh);
    endfunction

endpackage
`default_nettype wire

[rtl/touch_baseline_tracker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// touch_baseline_tracker: per-channel capacitive touch baseline tracking
// Calibrates each channel from its first samples, then runs an IIR on the
// samples, compares against baseline plus delta and adapts the baseline.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock while the output side is not
// stalled and returns one result word per sample: the sample is captured in
// an input register, and once the result register is free or being read, the
// channel's filtered value, touch decision and baseline are updated in one
// pass (two shift-and-add IIR steps and a 16-bit compare) and loaded into the
// result register. The result register lets a new sample enter while a result
// waits. Samples of the same channel may follow each other in back-to-back
// cycles. The first CALIB_SAMPLES samples of each channel are calibration
// samples (calibrating set, touched clear); their truncated mean seeds both
// levels. Configuration writes are always accepted and should be issued only
// while no sample is in flight.
module touch_baseline_tracker (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // sample input
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire  [tbt_pkg::CH_W-1:0]      i_channel,
    input  wire  [tbt_pkg::LEVEL_W-1:0]   i_sample,
    // result output
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [tbt_pkg::CH_W-1:0]      o_out_channel,
    output logic                          o_touched,
    output logic [tbt_pkg::LEVEL_W-1:0]   o_filtered_level,
    output logic [tbt_pkg::LEVEL_W-1:0]   o_baseline_level,
    output logic                          o_calibrating,
    // configuration writes
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [tbt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [tbt_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import tbt_pkg::*;

    // configuration registers
    t_level              r_touch_delta;
    logic [SHIFT_W-1:0]  r_filter_shift;
    logic [SHIFT_W-1:0]  r_baseline_shift;

    // per-channel state
    t_level r_filt  [CHANNELS];
    t_level r_base  [CHANNELS];
    t_sum   r_sum   [CHANNELS];
    t_count r_count [CHANNELS];

    // input register
    logic              r_in_valid;
    logic [CH_W-1:0]   r_in_channel;
    t_level            r_in_sample;

    // result register
    logic              r_out_valid;
    logic [CH_W-1:0]   r_out_channel;
    logic              r_out_touched;
    t_level            r_out_filt;
    t_level            r_out_base;
    logic              r_out_calib;

    // update path
    logic   w_advance;
    logic   w_calib;
    logic   w_last;
    logic   w_touch_raw;
    t_count w_cnt;
    t_sum   n_sum;
    t_count n_count;
    t_level w_mean;
    t_level w_filt_iir;
    t_level w_base_iir;
    t_level w_thr;
    t_level n_filt;
    t_level n_base;
    logic   n_touched;

    // handshake
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_delta    <= TOUCH_DELTA_RST;
            r_filter_shift   <= FILTER_SHIFT_RST;
            r_baseline_shift <= BASELINE_SHIFT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_TOUCH_DELTA:    r_touch_delta    <= LEVEL_W'(i_cfg_data);
                REG_FILTER_SHIFT:   r_filter_shift   <= i_cfg_data[SHIFT_W-1:0];
                REG_BASELINE_SHIFT: r_baseline_shift <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_channel <= i_channel;
            r_in_sample  <= i_sample;
        end
    end

    // calibration bookkeeping
    always_comb begin
        w_cnt   = r_count[r_in_channel];
        w_calib = (w_cnt < COUNT_W'(CALIB_SAMPLES));
        n_sum   = r_sum[r_in_channel] + SUM_W'(r_in_sample);
        n_count = w_cnt + COUNT_W'(1);
        w_last  = (n_count == COUNT_W'(CALIB_SAMPLES));
        w_mean  = LEVEL_W'(n_sum / SUM_W'(CALIB_SAMPLES));
    end

    // filter, touch decision and baseline adaptation
    always_comb begin
        w_filt_iir  = iir_step(r_filt[r_in_channel], r_in_sample, r_filter_shift);
        w_thr       = r_base[r_in_channel] + r_touch_delta;
        w_touch_raw = (w_filt_iir > w_thr);
        w_base_iir  = iir_step(r_base[r_in_channel], w_filt_iir, r_baseline_shift);
        if (w_calib) begin
            n_touched = 1'b0;
            n_filt    = w_last ? w_mean : r_filt[r_in_channel];
            n_base    = w_last ? w_mean : r_base[r_in_channel];
        end else begin
            n_touched = w_touch_raw;
            n_filt    = w_filt_iir;
            n_base    = w_touch_raw ? r_base[r_in_channel] : w_base_iir;
        end
    end

    // channel state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_filt[i]  <= '0;
                r_base[i]  <= '0;
                r_sum[i]   <= '0;
                r_count[i] <= '0;
            end
        end else if (w_advance) begin
            r_filt[r_in_channel] <= n_filt;
            r_base[r_in_channel] <= n_base;
            if (w_calib) begin
                r_sum[r_in_channel]   <= n_sum;
                r_count[r_in_channel] <= n_count;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_channel <= r_in_channel;
            r_out_touched <= n_touched;
            r_out_filt    <= n_filt;
            r_out_base    <= n_base;
            r_out_calib   <= w_calib;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_channel    = r_out_channel;
    assign o_touched        = r_out_touched;
    assign o_filtered_level = r_out_filt;
    assign o_baseline_level = r_out_base;
    assign o_calibrating    = r_out_calib;

`ifndef ASSERT_OFF
    // a calibration result never reports touch
    a_calib_no_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_calibrating |-> !o_touched)
        else $error("touch reported on a calibration result");

    // calibration count never runs past the calibration length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (r_count[r_in_channel] <= COUNT_W'(CALIB_SAMPLES)))
        else $error("calibration count beyond calibration length");

    // a word leaving the input register shows up as a result next cycle
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> o_out_valid)
        else $error("result lost after input register advanced");

    // a stalled result keeps the input stage from overwriting it
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(r_out_filt)
            && $stable(r_out_base))
        else $error("stalled result overwritten");

    // nothing valid right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_in_valid)
        else $error("valid state after reset");
`endif

endmodule
`default_nettype wire

[bench/touch_baseline_tracker_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_baseline_tracker_tb: self-checking bench for the touch baseline tracker
// Calibrates both channels, then runs directed and random sample words under
// several register settings. A local model of the filtered value, touch
// decision and baseline predicts every result word, which is checked field by
// field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module touch_baseline_tracker_tb;
    import tbt_pkg::*;

    // index with no register behind it, writes are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic   ch;
        t_level smp;
    } t_sample;

    typedef struct packed {
        logic   ch;
        logic   touched;
        t_level filt;
        t_level base;
        logic   calib;
    } t_result;

    logic i_clk;
    logic rst_n = 1'b0;

    // dut side signals
    logic                 in_valid   = 1'b0;
    logic                 in_channel = 1'b0;
    t_level               in_sample  = '0;
    logic                 out_ready  = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CFG_DAT_W-1:0] cfg_data   = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_out_channel;
    logic                 o_touched;
    t_level               o_filtered_level;
    t_level               o_baseline_level;
    logic                 o_calibrating;
    logic                 o_cfg_ready;

    // stimulus and scoreboard
    t_sample sample_queue[$];
    t_result expected_levels[$];
    t_sample next_word;
    t_result got_word;
    t_result exp_word;
    int      samples_sent  = 0;
    int      samples_taken = 0;
    int      errors        = 0;
    int      send_gap      = 0;
    int      hold_gap      = 0;
    int      idle_cycles   = 0;
    bit      no_idle       = 1'b0;

    // local copy of tracker state and registers
    t_level          filt_q[2];
    t_level          base_q[2];
    logic [20:0]     cal_sum[2];
    int              cal_cnt[2];
    t_level          delta_cfg  = TOUCH_DELTA_RST;
    logic [3:0]      fshift_cfg = FILTER_SHIFT_RST;
    logic [3:0]      bshift_cfg = BASELINE_SHIFT_RST;

    // random stimulus shaping, per phase
    logic   touching[2];
    t_level center[2];
    int     noise_amp;
    int     bump;

    touch_baseline_tracker i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_channel        (in_channel),
        .i_sample         (in_sample),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_out_channel    (o_out_channel),
        .o_touched        (o_touched),
        .o_filtered_level (o_filtered_level),
        .o_baseline_level (o_baseline_level),
        .o_calibrating    (o_calibrating),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // first-order blend: (prev*(2^sh-1) + fresh) >> sh
    function automatic t_level iir_blend(input t_level prev, input t_level fresh,
                                         input logic [3:0] sh);
        logic [35:0] acc;
        acc = {20'b0, prev} * ((36'd1 << sh) - 36'd1) + {20'b0, fresh};
        return t_level'(acc >> sh);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // update the tracker model with one accepted word and queue its result
    task automatic track_sample(input logic ch, input t_level smp);
        t_result r;
        t_level thr;
        r.ch      = ch;
        r.touched = 1'b0;
        r.calib   = 1'b0;
        if (cal_cnt[ch] < CALIB_SAMPLES) begin
            r.calib     = 1'b1;
            cal_sum[ch] = cal_sum[ch] + smp;
            cal_cnt[ch] = cal_cnt[ch] + 1;
            if (cal_cnt[ch] == CALIB_SAMPLES) begin
                filt_q[ch] = t_level'(cal_sum[ch] / CALIB_SAMPLES);
                base_q[ch] = filt_q[ch];
            end
        end else begin
            filt_q[ch] = iir_blend(filt_q[ch], smp, fshift_cfg);
            thr        = base_q[ch] + delta_cfg;
            r.touched  = filt_q[ch] > thr;
            if (!r.touched)
                base_q[ch] = iir_blend(base_q[ch], filt_q[ch], bshift_cfg);
        end
        r.filt = filt_q[ch];
        r.base = base_q[ch];
        expected_levels.push_back(r);
    endtask

    task automatic queue_sample(input logic ch, input t_level smp);
        sample_queue.push_back('{ch: ch, smp: smp});
        samples_sent++;
    endtask

    // random sample near the channel level, with touch bumps, some noise and occasional random or extreme values
    function automatic t_level make_sample(input logic ch);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 5)
            return t_level'($urandom);
        if (r < 7)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(0, 99) < 4)
            touching[ch] = ~touching[ch];
        v = int'(center[ch]) + $urandom_range(0, noise_amp) - noise_amp / 2;
        if (touching[ch])
            v = v + bump;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return t_level'(v);
    endfunction

    // one register write word, the model follows at acceptance
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_TOUCH_DELTA:    delta_cfg  = val;
            REG_FILTER_SHIFT:   fshift_cfg = val[3:0];
            REG_BASELINE_SHIFT: bshift_cfg = val[3:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // wait for every sent word to come back, plus the pipeline depth
    task automatic wait_idle();
        while (samples_taken != samples_sent || expected_levels.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [3:0] pick_shift();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 4'd0;
        if (r < 30)
            return 4'd15;
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic t_level pick_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'h0000;
        if (r < 20)
            return 16'hFFFF;
        if (r < 35)
            return t_level'($urandom);
        return t_level'($urandom_range(1, 300));
    endfunction

    // new random settings between phases
    task automatic retune();
        if ($urandom_range(0, 2) != 0)
            write_reg(REG_TOUCH_DELTA, pick_delta());
        if ($urandom_range(0, 2) != 0)
            write_reg(REG_FILTER_SHIFT, {12'($urandom), pick_shift()});
        if ($urandom_range(0, 2) != 0)
            write_reg(REG_BASELINE_SHIFT, {12'($urandom), pick_shift()});
        if ($urandom_range(0, 5) == 0)
            write_reg(REG_UNUSED, 16'($urandom));
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                track_sample(in_channel, in_sample);
                samples_taken++;
            end
            if (!in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (sample_queue.size() != 0) begin
                    next_word = sample_queue.pop_front();
                    in_valid   <= 1'b1;
                    in_channel <= next_word.ch;
                    in_sample  <= next_word.smp;
                    send_gap   = pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stalls
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                got_word = '{ch: o_out_channel, touched: o_touched, filt: o_filtered_level,
                             base: o_baseline_level, calib: o_calibrating};
                if (expected_levels.size() == 0) begin
                    $error("result word with nothing expected: %p", got_word);
                    errors++;
                end else begin
                    exp_word = expected_levels.pop_front();
                    if (got_word.ch !== exp_word.ch) begin
                        $error("out_channel: expected %0d, got %0d", exp_word.ch, got_word.ch);
                        errors++;
                    end
                    if (got_word.touched !== exp_word.touched) begin
                        $error("touched: expected %0d, got %0d",
                               exp_word.touched, got_word.touched);
                        errors++;
                    end
                    if (got_word.filt !== exp_word.filt) begin
                        $error("filtered_level: expected %0d, got %0d",
                               exp_word.filt, got_word.filt);
                        errors++;
                    end
                    if (got_word.base !== exp_word.base) begin
                        $error("baseline_level: expected %0d, got %0d",
                               exp_word.base, got_word.base);
                        errors++;
                    end
                    if (got_word.calib !== exp_word.calib) begin
                        $error("calibrating: expected %0d, got %0d",
                               exp_word.calib, got_word.calib);
                        errors++;
                    end
                end
            end
            if (hold_gap > 0) begin
                hold_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                hold_gap  = pick_gap();
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("touch_baseline_tracker test failed");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial begin
        int n;
        for (int c = 0; c < 2; c++) begin
            filt_q[c]   = '0;
            base_q[c]   = '0;
            cal_sum[c]  = '0;
            cal_cnt[c]  = 0;
            touching[c] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // calibration of both channels, extremes mixed in, reset settings
        for (int k = 0; k < 2 * CALIB_SAMPLES; k++) begin
            if (k == 3 || k == 40)
                queue_sample(k[0], 16'h0000);
            else if (k == 6 || k == 51)
                queue_sample(k[0], 16'hFFFF);
            else if (k[0])
                queue_sample(1'b1, t_level'($urandom_range(38000, 42000)));
            else
                queue_sample(1'b0, t_level'($urandom_range(11000, 13000)));
        end
        // extremes right after calibration, still at reset settings
        queue_sample(1'b0, 16'h0000);
        queue_sample(1'b0, 16'hFFFF);
        queue_sample(1'b1, 16'hFFFF);
        queue_sample(1'b1, 16'h0000);
        wait_idle();

        // zero shifts replace outright, zero delta touches on any rise
        write_reg(REG_TOUCH_DELTA, 16'h0000);
        write_reg(REG_FILTER_SHIFT, 16'hFFF0);
        write_reg(REG_BASELINE_SHIFT, 16'h0000);
        queue_sample(1'b0, 16'd5000);
        queue_sample(1'b0, 16'd5001);
        queue_sample(1'b0, 16'd5001);
        queue_sample(1'b0, 16'h0000);
        queue_sample(1'b1, 16'hFFFF);
        queue_sample(1'b1, 16'hFFFF);
        wait_idle();

        // largest delta wraps the threshold, largest shifts, unused index
        write_reg(REG_TOUCH_DELTA, 16'hFFFF);
        write_reg(REG_FILTER_SHIFT, 16'h000F);
        write_reg(REG_BASELINE_SHIFT, 16'hFFFF);
        write_reg(REG_UNUSED, 16'hFFFF);
        queue_sample(1'b0, 16'hFFFF);
        queue_sample(1'b0, 16'h0000);
        queue_sample(1'b1, 16'h0000);
        queue_sample(1'b1, 16'hFFFF);
        queue_sample(1'b0, 16'hFFFF);
        wait_idle();

        // random phases, each with its own settings and idling
        for (int p = 0; p < 12; p++) begin
            retune();
            no_idle   = ($urandom_range(0, 3) == 0);
            noise_amp = $urandom_range(0, 64);
            bump      = $urandom_range(20, 2000);
            center[0] = base_q[0];
            center[1] = base_q[1];
            n = $urandom_range(80, 120);
            for (int k = 0; k < n; k++) begin
                logic ch;
                ch = 1'($urandom_range(0, 1));
                queue_sample(ch, make_sample(ch));
            end
            wait_idle();
        end

        repeat (6) @(posedge i_clk);
        if (errors == 0)
            $display("touch_baseline_tracker test passed");
        else
            $display("touch_baseline_tracker test failed");
        $finish;
    end

endmodule
